@@ rtl/core/aht_pkg.sv @@
`default_nettype none

package aht_pkg;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEF     = 128;
    localparam int ADDR_BITS_DEF = 48;

    // Fixed field widths of the two streams.
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 31;
    localparam int TAG_W    = 32;
    localparam int LIVE_W   = 8;
    localparam int TOTAL_W  = 32;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 136;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_LOAD_LIMIT = 1'b0;
    localparam logic [LIVE_W-1:0] LOAD_LIMIT_RST = 8'd90;

    // Slot tag codes; any other tag value is a key hash.
    localparam logic [TAG_W-1:0] TAG_EMPTY   = 32'd0;
    localparam logic [TAG_W-1:0] TAG_DELETED = 32'd1;
    localparam logic [TAG_W-1:0] TAG_MIN     = 32'd2;

    localparam logic [63:0] HASH_MULT = 64'hFF51AFD7ED558CCD;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_RECORDED = 3'd0,
        ST_RELEASED = 3'd1,
        ST_DOUBLE   = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_FULL     = 3'd4,
        ST_NULL     = 3'd5
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/aht_hash.sv @@
`default_nettype none

// Sequenced key hash: one 32x32 multiplier is reused for the three partial
// products of the 64-bit multiply, then the tag is reduced to a home slot,
// four remainder bits per cycle when the slot count is not a power of two.
module aht_hash import aht_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] key,
    output logic                   done,
    output logic [TAG_W-1:0]       tag,
    output logic [SLOT_W-1:0]      home
);

    localparam bit SLOTS_POW2   = (SLOTS & (SLOTS - 1)) == 0;
    localparam int DIGIT_W      = 4;
    localparam int MOD_STEPS    = TAG_W / DIGIT_W;
    localparam int STEP_W       = $clog2(MOD_STEPS);
    localparam int REM_W        = SLOT_W + 1;

    typedef enum logic [2:0] {
        H_IDLE,
        H_MUL0,
        H_MUL1,
        H_MUL2,
        H_FOLD,
        H_MOD
    } hstate_t;

    hstate_t             state_reg;
    logic [63:0]         x_reg;
    logic [63:0]         prod_reg;
    logic [31:0]         lo_reg;
    logic [31:0]         hi_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    shift_reg;
    logic [SLOT_W-1:0]   rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;

    logic [63:0]         x_key;
    logic [63:0]         x_mix;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [63:0]         x_full;
    logic [63:0]         x_fold;
    logic [TAG_W-1:0]    tag_fix;
    logic [SLOT_W-1:0]   rem_step;

    assign x_key = {{(64-ADDR_W){1'b0}}, key} >> 3;
    assign x_mix = x_key ^ (x_key >> 33);

    always_comb begin
        unique case (state_reg)
            H_MUL1: begin
                mul_a = x_reg[31:0];
                mul_b = HASH_MULT[63:32];
            end
            H_MUL2: begin
                mul_a = x_reg[63:32];
                mul_b = HASH_MULT[31:0];
            end
            default: begin
                mul_a = x_reg[31:0];
                mul_b = HASH_MULT[31:0];
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign x_full  = {hi_reg + prod_reg[31:0], lo_reg};
    assign x_fold  = x_full ^ (x_full >> 33);
    assign tag_fix = (x_fold[TAG_W-1:0] < TAG_MIN) ? TAG_MIN : x_fold[TAG_W-1:0];

    // Restoring reduction of one digit of the tag, most significant first.
    always_comb begin
        logic [REM_W-1:0] r;
        r = '0;
        r[SLOT_W-1:0] = rem_reg;
        for (int i = 0; i < DIGIT_W; i++) begin
            r = {r[SLOT_W-1:0], shift_reg[TAG_W-1-i]};
            if (r >= REM_W'(SLOTS)) begin
                r = r - REM_W'(SLOTS);
            end
        end
        rem_step = r[SLOT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        x_reg     <= x_mix;
                        state_reg <= H_MUL0;
                    end
                end
                H_MUL0: begin
                    prod_reg  <= mul_p;
                    state_reg <= H_MUL1;
                end
                H_MUL1: begin
                    prod_reg  <= mul_p;
                    lo_reg    <= prod_reg[31:0];
                    hi_reg    <= prod_reg[63:32];
                    state_reg <= H_MUL2;
                end
                H_MUL2: begin
                    prod_reg  <= mul_p;
                    hi_reg    <= hi_reg + prod_reg[31:0];
                    state_reg <= H_FOLD;
                end
                H_FOLD: begin
                    tag_reg   <= tag_fix;
                    shift_reg <= tag_fix;
                    step_reg  <= '0;
                    if (SLOTS_POW2) begin
                        rem_reg   <= tag_fix[SLOT_W-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end else begin
                        rem_reg   <= '0;
                        state_reg <= H_MOD;
                    end
                end
                H_MOD: begin
                    rem_reg   <= rem_step;
                    shift_reg <= shift_reg << DIGIT_W;
                    step_reg  <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(MOD_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                end
                default: begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign tag  = tag_reg;
    assign home = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/aht_store.sv @@
`default_nettype none

// Slot memories: tag, key and size, one write port and one read port with
// registered read data.
module aht_store import aht_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int KEY_W = ADDR_W,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic              aclk,
    input  wire logic [SLOT_W-1:0] rd_slot,
    output logic [TAG_W-1:0]       rd_tag,
    output logic [KEY_W-1:0]       rd_key,
    output logic [SIZE_W-1:0]      rd_size,
    input  wire logic              wr_en,
    input  wire logic              wr_full,
    input  wire logic [SLOT_W-1:0] wr_slot,
    input  wire logic [TAG_W-1:0]  wr_tag,
    input  wire logic [KEY_W-1:0]  wr_key,
    input  wire logic [SIZE_W-1:0] wr_size
);

    logic [TAG_W-1:0]  tag_mem  [SLOTS];
    logic [KEY_W-1:0]  key_mem  [SLOTS];
    logic [SIZE_W-1:0] size_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_slot] <= wr_tag;
        end
        rd_tag <= tag_mem[rd_slot];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_full) begin
            key_mem[wr_slot]  <= wr_key;
            size_mem[wr_slot] <= wr_size;
        end
        rd_key  <= key_mem[rd_slot];
        rd_size <= size_mem[rd_slot];
    end

endmodule

`default_nettype wire

@@ rtl/core/allocation_tracking_hash_table.sv @@
`default_nettype none

// Channel     Direction  Handshake          Content
// s_ (input)  in         s_tvalid/s_tready  tuser: kind; tdata: address, size
// m_ (result) out        m_tvalid/m_tready  tuser: status; tdata: size, counts
// APB config  in         psel/penable       load_limit at byte address 0
//
// A transaction for a power-of-two SLOTS goes through these steps: accept, hash (three
// multiplier passes, a fold, the done hand-off), probe with registered reads over the
// slots probed, and load the result; other slot counts add the remainder steps. Null
// addresses and inserts refused at the limit skip the hash and the probe.
// After reset the tag memory is cleared before s_tready rises.
// While a result stalls, the next item is accepted and then holds until it is taken.
module allocation_tracking_hash_table import aht_pkg::*; #(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int ADDRESS_BITS = ADDR_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // address[47:0], size[78:48], zero pad
    input  wire logic                 s_tuser,   // kind
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // released_size[30:0], live_entries[38:31],
                                                 // allocation_total[70:39],
                                                 // release_total[102:71],
                                                 // imbalance[134:103], zero pad
    output logic [STATUS_W-1:0]       m_tuser,   // status
    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int N_W    = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int KEY_W  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((65'(1) << ADDRESS_BITS) - 65'(1));

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        HASH,
        PROBE,
        DONE
    } state_t;

    state_t               state_reg;
    logic [SLOT_W-1:0]    clr_idx_reg;
    logic                 kind_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [SIZE_W-1:0]    size_reg;
    status_t              status_reg;
    logic [SIZE_W-1:0]    rsize_reg;
    logic [LIVE_W-1:0]    live_reg;
    logic [LIVE_W-1:0]    limit_reg;
    logic [TOTAL_W-1:0]   alloc_reg;
    logic [TOTAL_W-1:0]   free_reg;
    logic [SLOT_W-1:0]    cur_slot_reg;
    logic [N_W-1:0]       n_reg;
    logic                 pend_valid_reg;
    logic [SLOT_W-1:0]    pend_slot_reg;
    logic                 del_seen_reg;
    logic [SLOT_W-1:0]    del_slot_reg;
    logic                 m_tvalid_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 accept;
    logic                 cfg_write;
    logic                 kind_in;
    logic [ADDR_W-1:0]    addr_in;
    logic [SIZE_W-1:0]    size_in;
    logic                 table_full;
    logic                 hash_start;
    logic                 hash_done;
    logic [TAG_W-1:0]     hash_tag;
    logic [SLOT_W-1:0]    hash_home;
    logic                 load_result;

    logic                 issue;
    logic [SUM_W-1:0]     step_sum;
    logic [SLOT_W-1:0]    next_slot;
    logic                 is_empty;
    logic                 is_hit;
    logic                 is_del;
    logic                 probe_end;
    logic                 has_room;
    logic [SLOT_W-1:0]    room_slot;
    logic [TOTAL_W-1:0]   imbalance;

    logic [SLOT_W-1:0]    rd_slot;
    logic [TAG_W-1:0]     rd_tag;
    logic [KEY_W-1:0]     rd_key;
    logic [SIZE_W-1:0]    rd_size;
    logic                 wr_en;
    logic                 wr_full;
    logic [SLOT_W-1:0]    wr_slot;
    logic [TAG_W-1:0]     wr_tag;

    // Stream and register port decode.
    assign s_tready  = (state_reg == IDLE);
    assign accept    = s_tvalid && s_tready;
    assign kind_in   = s_tuser;
    assign addr_in   = s_tdata[ADDR_W-1:0] & ADDR_MASK;
    assign size_in   = s_tdata[ADDR_W +: SIZE_W];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[APB_AW-1:2] == REG_LOAD_LIMIT) ? APB_DW'(limit_reg) : '0;

    // An insert is refused up front once the live count reaches the limit or the slot count.
    assign table_full = (live_reg >= limit_reg) || (TOTAL_W'(live_reg) >= TOTAL_W'(SLOTS));
    assign hash_start = accept && (addr_in != '0) &&
                        !((kind_in == KIND_RECORD) && table_full);

    // The finished result moves to the output register once it is free.
    assign load_result = (state_reg == DONE) && (!m_tvalid_reg || m_tready);

    aht_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (addr_in),
        .done    (hash_done),
        .tag     (hash_tag),
        .home    (hash_home)
    );

    // The probe path does not depend on the data read, so a new slot is read
    // every cycle while the slot read before it is being examined.
    assign issue     = (n_reg < N_W'(SLOTS));
    assign step_sum  = SUM_W'(cur_slot_reg) + SUM_W'(n_reg) + SUM_W'(1);
    assign next_slot = (step_sum >= SUM_W'(SLOTS)) ? SLOT_W'(step_sum - SUM_W'(SLOTS))
                                                   : SLOT_W'(step_sum);

    assign is_empty  = (rd_tag == TAG_EMPTY);
    assign is_hit    = (rd_tag == hash_tag) && (rd_key == addr_reg[KEY_W-1:0]);
    assign is_del    = (rd_tag == TAG_DELETED);
    // The walk stops at an empty slot, at the key, or after the last slot.
    assign probe_end = pend_valid_reg && (is_empty || is_hit || !issue);

    // Inserts reuse the most recent deleted slot on the path, otherwise the
    // empty slot that ended the walk.
    assign has_room  = del_seen_reg || is_del || is_empty;
    assign room_slot = is_del       ? pend_slot_reg :
                       del_seen_reg ? del_slot_reg  : pend_slot_reg;

    assign imbalance = (alloc_reg > free_reg) ? (alloc_reg - free_reg)
                                              : (free_reg - alloc_reg);

    always_comb begin
        rd_slot = cur_slot_reg;
        wr_en   = 1'b0;
        wr_full = 1'b0;
        wr_slot = pend_slot_reg;
        wr_tag  = TAG_DELETED;
        if (state_reg == CLEAR) begin
            wr_en   = 1'b1;
            wr_slot = clr_idx_reg;
            wr_tag  = TAG_EMPTY;
        end else if ((state_reg == PROBE) && probe_end) begin
            if (is_hit && (kind_reg == KIND_RELEASE)) begin
                wr_en = 1'b1;
            end else if (!is_hit && (kind_reg == KIND_RECORD) && has_room) begin
                wr_en   = 1'b1;
                wr_full = 1'b1;
                wr_slot = room_slot;
                wr_tag  = hash_tag;
            end
        end
    end

    aht_store #(
        .SLOTS (SLOTS),
        .KEY_W (KEY_W)
    ) u_store (
        .aclk    (aclk),
        .rd_slot (rd_slot),
        .rd_tag  (rd_tag),
        .rd_key  (rd_key),
        .rd_size (rd_size),
        .wr_en   (wr_en),
        .wr_full (wr_full),
        .wr_slot (wr_slot),
        .wr_tag  (wr_tag),
        .wr_key  (addr_reg[KEY_W-1:0]),
        .wr_size (size_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= CLEAR;
            clr_idx_reg    <= '0;
            live_reg       <= '0;
            limit_reg      <= LOAD_LIMIT_RST;
            alloc_reg      <= '0;
            free_reg       <= '0;
            pend_valid_reg <= 1'b0;
            del_seen_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_write && (paddr[APB_AW-1:2] == REG_LOAD_LIMIT)) begin
                limit_reg <= pwdata[LIVE_W-1:0];
            end
            if (load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                    if (clr_idx_reg == SLOT_W'(SLOTS - 1)) begin
                        state_reg <= IDLE;
                    end
                end
                IDLE: begin
                    if (accept) begin
                        kind_reg  <= kind_in;
                        addr_reg  <= addr_in;
                        size_reg  <= size_in;
                        rsize_reg <= '0;
                        if (addr_in == '0) begin
                            status_reg <= ST_NULL;
                            state_reg  <= DONE;
                        end else if (kind_in == KIND_RECORD) begin
                            alloc_reg <= alloc_reg + TOTAL_W'(1);
                            if (table_full) begin
                                status_reg <= ST_FULL;
                                state_reg  <= DONE;
                            end else begin
                                state_reg <= HASH;
                            end
                        end else begin
                            free_reg  <= free_reg + TOTAL_W'(1);
                            state_reg <= HASH;
                        end
                    end
                end
                HASH: begin
                    if (hash_done) begin
                        cur_slot_reg   <= hash_home;
                        n_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        del_seen_reg   <= 1'b0;
                        state_reg      <= PROBE;
                    end
                end
                PROBE: begin
                    pend_valid_reg <= issue;
                    if (issue) begin
                        cur_slot_reg  <= next_slot;
                        n_reg         <= n_reg + N_W'(1);
                        pend_slot_reg <= cur_slot_reg;
                    end
                    if (pend_valid_reg && is_del) begin
                        del_seen_reg <= 1'b1;
                        del_slot_reg <= pend_slot_reg;
                    end
                    if (probe_end) begin
                        state_reg <= DONE;
                        if (kind_reg == KIND_RECORD) begin
                            if (is_hit) begin
                                status_reg <= ST_DOUBLE;
                            end else if (has_room) begin
                                live_reg   <= live_reg + LIVE_W'(1);
                                status_reg <= ST_RECORDED;
                            end else begin
                                status_reg <= ST_FULL;
                            end
                        end else begin
                            if (is_hit) begin
                                if (live_reg != '0) begin
                                    live_reg <= live_reg - LIVE_W'(1);
                                end
                                rsize_reg  <= rd_size;
                                status_reg <= ST_RELEASED;
                            end else begin
                                status_reg <= ST_UNKNOWN;
                            end
                        end
                    end
                end
                DONE: begin
                    // Load the result only once the previous one is taken.
                    if (load_result) begin
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {1'b0, imbalance, free_reg, alloc_reg,
                                         live_reg, rsize_reg};
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
